@@ hdl/skit_pkg.sv @@
// shared types and constants for the sorted key index table
// no dependencies; imported by every module of the block
package skit_pkg;

  // table depth and derived widths
  localparam int ENTRIES = 64;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // item field widths
  localparam int KIND_W = 2;
  localparam int KEY_W  = 32;
  localparam int OFS_W  = 31;
  localparam int STAT_W = 2;
  localparam int ECNT_W = 7;

  // stream widths
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = STAT_W + OFS_W + ECNT_W;

  // operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_DELETE = 2'd2
  } skit_kind_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_DONE = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } skit_status_e;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic                    cmp;
    logic                    ins;
    logic                    del;
    logic signed [KEY_W-1:0] key;
    logic        [OFS_W-1:0] ofs;
  } skit_cmd_t;

endpackage

@@ hdl/skit_cell.sv @@
// one entry of the sorted chain: key, offset and the compare flags
// depends on skit_pkg; instantiated ENTRIES times by sorted_key_index_table
module skit_cell import skit_pkg::*; (
  input  logic                    clk_i,
  input  skit_cmd_t               cmd_i,
  input  logic                    valid_i,
  input  logic                    prev_lt_i,
  input  logic signed [KEY_W-1:0] left_key_i,
  input  logic        [OFS_W-1:0] left_ofs_i,
  input  logic signed [KEY_W-1:0] right_key_i,
  input  logic        [OFS_W-1:0] right_ofs_i,
  output logic signed [KEY_W-1:0] key_o,
  output logic        [OFS_W-1:0] ofs_o,
  output logic                    lt_o,
  output logic                    first_o
);

  logic signed [KEY_W-1:0] key_q, key_d;
  logic        [OFS_W-1:0] ofs_q, ofs_d;
  logic                    lt_q, eq_q;

  // compare stage: flags against the broadcast key
  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      lt_q <= valid_i && (key_q < cmd_i.key);
      eq_q <= valid_i && (key_q == cmd_i.key);
    end
  end

  // entries at or past the boundary open a gap or close one
  always_comb begin
    key_d = key_q;
    ofs_d = ofs_q;
    if (cmd_i.ins && !lt_q) begin
      if (prev_lt_i) begin
        key_d = cmd_i.key;
        ofs_d = cmd_i.ofs;
      end else begin
        key_d = left_key_i;
        ofs_d = left_ofs_i;
      end
    end else if (cmd_i.del && !lt_q) begin
      key_d = right_key_i;
      ofs_d = right_ofs_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    ofs_q <= ofs_d;
  end

  assign key_o   = key_q;
  assign ofs_o   = ofs_q;
  assign lt_o    = lt_q;
  // sorted order: the first equal entry sits right after the last smaller one
  assign first_o = eq_q && prev_lt_i;

endmodule

@@ hdl/sorted_key_index_table.sv @@
// Sorted key index table, top level.
// Keeps up to ENTRIES (key, offset) pairs in ascending signed key order in a
// chain of cells, each cell holding one entry and trading it with its
// neighbors when an entry is inserted or removed.
// Input item: s_axis_tuser_i carries the operation (insert, lookup, delete),
// s_axis_tdata_i carries the key and the offset. An insert goes in front of
// the first entry with an equal or greater key; lookup and delete act on the
// first entry with an equal key. Each input item yields one result item on
// the m_axis group: status, offset found by a lookup, and the entry count.
// Each item passes through a compare phase (every cell compares its entry
// with the key) and an execute phase (cells shift, result is registered).
// No new item is taken during the compare phase; the next item is taken in
// the same cycle the result of the current one is registered.
// When the receiver stalls the result stays in the output register; the
// block then holds the pending operation and takes no new item until the
// output register frees up.
// Reset empties the table at once (the entry count goes to zero) and clears
// the output valid; no clearing pass is needed.
module sorted_key_index_table import skit_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // key[31:0], offset[62:32], zero[63]
  input  logic [KIND_W-1:0]     s_axis_tuser_i,  // kind[1:0]
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o   // status[1:0], found_offset[32:2],
                                                 // entry_count[39:33]
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EXEC
  } state_e;

  state_e                  state_q;
  logic [KIND_W-1:0]       kind_q;
  logic signed [KEY_W-1:0] key_q;
  logic [OFS_W-1:0]        ofs_q;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    out_valid_q;
  logic [OUT_DATA_W-1:0]   out_data_q;

  skit_cmd_t               cmd;
  logic                    accept, apply, full, hit;
  skit_status_e            status;
  logic [OFS_W-1:0]        found;

  logic signed [KEY_W-1:0] cell_key [ENTRIES];
  logic [OFS_W-1:0]        cell_ofs [ENTRIES];
  logic [ENTRIES-1:0]      cell_lt;
  logic [ENTRIES-1:0]      cell_first;

  // handshake and phase control
  assign apply           = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = (state_q == ST_IDLE) || apply;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = (count_q == CNT_W'(ENTRIES));
  assign hit             = |cell_first;

  // command broadcast to the chain
  always_comb begin
    cmd.cmp = (state_q == ST_CMP);
    cmd.ins = apply && (kind_q == KIND_INSERT) && !full;
    cmd.del = apply && (kind_q == KIND_DELETE) && hit;
    cmd.key = key_q;
    cmd.ofs = ofs_q;
  end

  // chain of cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic                    prev_lt;
    logic signed [KEY_W-1:0] left_key, right_key;
    logic [OFS_W-1:0]        left_ofs, right_ofs;

    if (i == 0) begin : g_head
      assign prev_lt  = 1'b1;
      assign left_key = '0;
      assign left_ofs = '0;
    end else begin : g_body
      assign prev_lt  = cell_lt[i-1];
      assign left_key = cell_key[i-1];
      assign left_ofs = cell_ofs[i-1];
    end

    if (i == ENTRIES - 1) begin : g_tail
      assign right_key = '0;
      assign right_ofs = '0;
    end else begin : g_next
      assign right_key = cell_key[i+1];
      assign right_ofs = cell_ofs[i+1];
    end

    skit_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .valid_i     (CNT_W'(i) < count_q),
      .prev_lt_i   (prev_lt),
      .left_key_i  (left_key),
      .left_ofs_i  (left_ofs),
      .right_key_i (right_key),
      .right_ofs_i (right_ofs),
      .key_o       (cell_key[i]),
      .ofs_o       (cell_ofs[i]),
      .lt_o        (cell_lt[i]),
      .first_o     (cell_first[i])
    );
  end

  // offset of the single first-equal entry
  always_comb begin
    found = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      found = found | (cell_ofs[i] & {OFS_W{cell_first[i]}});
    end
  end

  // result of the pending operation
  always_comb begin
    status  = STAT_DONE;
    count_d = count_q;
    case (kind_q)
      KIND_INSERT: begin
        if (full) begin
          status = STAT_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      KIND_LOOKUP: begin
        if (!hit) begin
          status = STAT_MISS;
        end
      end
      KIND_DELETE: begin
        if (hit) begin
          count_d = count_q - CNT_W'(1);
        end else begin
          status = STAT_MISS;
        end
      end
      default: ;
    endcase
  end

  // state, operation registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= ST_CMP;
        kind_q  <= s_axis_tuser_i;
        key_q   <= s_axis_tdata_i[KEY_W-1:0];
        ofs_q   <= s_axis_tdata_i[KEY_W+OFS_W-1:KEY_W];
      end else if (state_q == ST_CMP) begin
        state_q <= ST_EXEC;
      end else if (apply) begin
        state_q <= ST_IDLE;
      end

      if (apply) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
        out_data_q  <= {ECNT_W'(count_d),
                        ((kind_q == KIND_LOOKUP) && hit) ? found : OFS_W'(0),
                        status};
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

@@ hdl/skit_checker.sv @@
// port-level checks for the sorted key index table
// depends on skit_pkg; bound to sorted_key_index_table at the end of this file
module skit_checker import skit_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic [STAT_W-1:0] out_status;
  logic [OFS_W-1:0]  out_found;
  logic [ECNT_W-1:0] out_count;

  assign out_status = m_axis_tdata_o[STAT_W-1:0];
  assign out_found  = m_axis_tdata_o[STAT_W+OFS_W-1:STAT_W];
  assign out_count  = m_axis_tdata_o[OUT_DATA_W-1:STAT_W+OFS_W];

  // one item in flight: no item is taken in the cycle after one is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input item accepted while the previous item is still in compare");

  // a refused insert only happens on a full table
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_status == STAT_FULL) |-> (out_count == ECNT_W'(ENTRIES)))
    else $error("table full reported with entry count below capacity");

  // a nonzero offset only comes back from a successful lookup
  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_found != '0) |-> (out_status == STAT_DONE))
    else $error("offset returned with a failing status");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result item changed or dropped");

endmodule

bind sorted_key_index_table skit_checker u_skit_checker (.*);
